>>> rtl/mavt_pkg.sv
// ----------------------------------------------------------------------------
// mavt_pkg
// Shared constants, function codes and the tag carried beside the divider.
// ----------------------------------------------------------------------------
package mavt_pkg;

  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int TARE_DEPTH_DEF   = 16;
  localparam int SAMPLE_BITS_DEF  = 24;

  localparam int FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_MEASURE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TARE    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

  typedef struct packed {
    logic complete;
    logic restart;
    logic flag;
  } mavt_tag_t;

endpackage

>>> rtl/moving_average_with_tare_capture_core.sv
// ----------------------------------------------------------------------------
// moving_average_with_tare_capture_core
// Moving average over a sample ring with tare calibration capture.
//
//   channel  dir  tdata                          tuser
//   s_*      in   [SB-1:0] sample                [1:0] func
//   m_*      out  [SB-1:0] average,              [0] tare_done
//                 [2SB-1:SB] tare_value
//
// One request per cycle unless the output stalls; every request gives one result.
// The accepting edge loads the request stage while the RAM reads the oldest
// entry; the sums are then updated and the divider loaded, its partial-product
// and sum-and-shift stages form the quotients by reciprocal multiplication,
// and the output register is loaded last.
// Reset clears the ring (through a fill mark), the sums and all valid bits.
// A held result stalls the pipeline only when its last stage is occupied.
// ----------------------------------------------------------------------------
module moving_average_with_tare_capture_core import mavt_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int TARE_DEPTH   = TARE_DEPTH_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,  // sample
  input  logic [FUNC_W-1:0]                       s_tuser,  // func
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,  // average, tare_value
  output logic [0:0]                              m_tuser   // tare_done
);

  localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int TSUM_W     = SAMPLE_BITS + $clog2(TARE_DEPTH);
  localparam int DIV_W      = (SUM_W > TSUM_W) ? SUM_W : TSUM_W;
  localparam int CNT_W      = (TARE_DEPTH > 1) ? $clog2(TARE_DEPTH) : 1;
  localparam int OUT_DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(TARE_DEPTH - 1);

  logic                          acc;
  logic                          adv;
  logic                          upd;
  logic                          s1_valid;
  logic [FUNC_W-1:0]             s1_func;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic signed [SUM_W-1:0]       sum_next;
  logic signed [TSUM_W-1:0]      tare_sum;
  logic signed [TSUM_W-1:0]      tsum_add;
  logic [CNT_W-1:0]              tare_count;
  logic                          tare_flag;
  logic                          flag_next;
  logic                          complete;
  logic                          restart;
  mavt_tag_t                     tag_in;
  mavt_tag_t                     tag_out;
  logic                          div_valid;
  logic signed [SAMPLE_BITS-1:0] avg;
  logic signed [SAMPLE_BITS-1:0] tare_quo;
  logic signed [SAMPLE_BITS-1:0] tare_avg;
  logic signed [SAMPLE_BITS-1:0] tare_now;
  logic                          out_load;

  assign adv      = !div_valid || !m_tvalid || m_tready;
  assign s_tready = !s1_valid || adv;
  assign acc      = s_tvalid && s_tready;
  assign upd      = s1_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_func   <= s_tuser;
      s1_sample <= s_tdata[SAMPLE_BITS-1:0];
    end
  end

  mavt_ring #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .acc_en     (acc),
    .acc_func   (s_tuser),
    .upd_en     (upd),
    .upd_func   (s1_func),
    .upd_sample (s1_sample),
    .sum_next   (sum_next)
  );

  assign tsum_add  = tare_sum + TSUM_W'(s1_sample);
  assign complete  = (s1_func == FUNC_TARE) && (tare_count == LAST_COUNT);
  assign restart   = (s1_func == FUNC_RESTART);
  assign flag_next = restart ? 1'b0 : (complete ? 1'b1 : tare_flag);

  always_ff @(posedge clk) begin
    if (rst) begin
      tare_sum   <= '0;
      tare_count <= '0;
      tare_flag  <= 1'b0;
    end else if (upd) begin
      case (s1_func)
        FUNC_TARE: begin
          if (complete) begin
            tare_sum   <= '0;
            tare_count <= '0;
          end else begin
            tare_sum   <= tsum_add;
            tare_count <= tare_count + 1'b1;
          end
        end
        FUNC_RESTART: begin
          tare_sum   <= '0;
          tare_count <= '0;
        end
        default: begin
        end
      endcase
      tare_flag <= flag_next;
    end
  end

  assign tag_in = '{complete: complete, restart: restart, flag: flag_next};

  mavt_divider #(
    .DIV_W     (DIV_W),
    .DIVISOR_A (WINDOW_DEPTH),
    .DIVISOR_B (TARE_DEPTH),
    .OUT_W     (SAMPLE_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s1_valid),
    .in_a      (DIV_W'(sum_next)),
    .in_b      (DIV_W'(tsum_add)),
    .in_tag    (tag_in),
    .out_valid (div_valid),
    .out_a     (avg),
    .out_b     (tare_quo),
    .out_tag   (tag_out)
  );

  assign out_load = adv && div_valid;
  assign tare_now = tag_out.restart ? '0 : (tag_out.complete ? tare_quo : tare_avg);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      tare_avg <= '0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
      tare_avg <= tare_now;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_DATA_W'({tare_now, avg});
      m_tuser <= tag_out.flag;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !out_load)
    else $error("held result overwritten");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    tare_count <= LAST_COUNT)
    else $error("tare count out of range");

  a_tare_clear: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] == '0))
    else $error("tare value set without done flag");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && div_valid && m_tvalid))
    else $error("input stalled with free pipeline");

endmodule

>>> rtl/mavt_ram.sv
// ----------------------------------------------------------------------------
// mavt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mavt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/mavt_ring.sv
// ----------------------------------------------------------------------------
// mavt_ring
// Sample ring in RAM with running window sum. Read the oldest entry on
// request, write the new sample to its slot on update, forward a same-slot write.
// ----------------------------------------------------------------------------
module mavt_ring import mavt_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                acc_en,
  input  logic [FUNC_W-1:0]                                   acc_func,
  input  logic                                                upd_en,
  input  logic [FUNC_W-1:0]                                   upd_func,
  input  logic signed [SAMPLE_BITS-1:0]                       upd_sample,
  output logic signed [SAMPLE_BITS+$clog2(WINDOW_DEPTH)-1:0]  sum_next
);

  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

  logic [SLOT_W-1:0]             slot;
  logic [SLOT_W-1:0]             slot_next;
  logic [SLOT_W-1:0]             upd_slot;
  logic                          wrapped;
  logic                          rd_en;
  logic                          wr_en;
  logic                          rd_valid;
  logic                          fwd_hit;
  logic                          fwd_hit_next;
  logic signed [SAMPLE_BITS-1:0] fwd_data;
  logic signed [SAMPLE_BITS-1:0] ram_q;
  logic signed [SAMPLE_BITS-1:0] oldest;
  logic signed [SUM_W-1:0]       window_sum;

  assign rd_en        = acc_en && (acc_func == FUNC_MEASURE);
  assign wr_en        = upd_en && (upd_func == FUNC_MEASURE);
  assign slot_next    = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
  assign fwd_hit_next = wr_en && (upd_slot == slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot       <= '0;
      wrapped    <= 1'b0;
      window_sum <= '0;
    end else begin
      if (rd_en) begin
        slot <= slot_next;
        if (slot == LAST_SLOT) begin
          wrapped <= 1'b1;
        end
      end
      if (wr_en) begin
        window_sum <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      upd_slot <= slot;
      rd_valid <= wrapped;
      fwd_hit  <= fwd_hit_next;
      fwd_data <= upd_sample;
    end
  end

  assign oldest   = fwd_hit ? fwd_data : (rd_valid ? ram_q : '0);
  assign sum_next = wr_en ? window_sum - SUM_W'(oldest) + SUM_W'(upd_sample) : window_sum;

  mavt_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (upd_slot),
    .wr_data (upd_sample),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (ram_q)
  );

endmodule

>>> rtl/mavt_divider.sv
// ----------------------------------------------------------------------------
// mavt_divider
// Two-lane pipelined divider by constants through reciprocal multiplication,
// truncating toward zero. Three stages: magnitude, partial products, then sum
// and shift. A tag travels alongside each request.
// ----------------------------------------------------------------------------
module mavt_divider import mavt_pkg::*; #(
  parameter int DIV_W     = 28,
  parameter int DIVISOR_A = 16,
  parameter int DIVISOR_B = 16,
  parameter int OUT_W     = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [DIV_W-1:0] in_a,
  input  logic signed [DIV_W-1:0] in_b,
  input  mavt_tag_t               in_tag,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_a,
  output logic signed [OUT_W-1:0] out_b,
  output mavt_tag_t               out_tag
);

  localparam int REC_W  = DIV_W + 1;
  localparam int LO_W   = (DIV_W + 1) / 2;
  localparam int HI_W   = DIV_W - LO_W;
  localparam int RLO_W  = (REC_W + 1) / 2;
  localparam int RHI_W  = REC_W - RLO_W;
  localparam int LL_W   = LO_W + RLO_W;
  localparam int LH_W   = LO_W + RHI_W;
  localparam int HL_W   = HI_W + RLO_W;
  localparam int HH_W   = HI_W + RHI_W;
  localparam int PROD_W = DIV_W + REC_W;

  logic             valid0;
  logic             valid1;
  logic             valid2;
  mavt_tag_t        tag0;
  mavt_tag_t        tag1;
  mavt_tag_t        tag2;
  logic [DIV_W-1:0] lane_quo [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else if (en) begin
      valid0 <= in_valid;
      valid1 <= valid0;
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag0 <= in_tag;
      tag1 <= tag0;
      tag2 <= tag1;
    end
  end

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    localparam int DIVISOR = (ln == 0) ? DIVISOR_A : DIVISOR_B;
    localparam int SHIFT   = DIV_W + $clog2(DIVISOR);
    localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
    localparam logic [REC_W-1:0] RECIP  = RECIP_FULL[REC_W-1:0];
    localparam logic [RLO_W-1:0] REC_LO = RECIP[RLO_W-1:0];
    localparam logic [RHI_W-1:0] REC_HI = RECIP[REC_W-1:RLO_W];

    logic signed [DIV_W-1:0] din;
    logic [DIV_W-1:0]        mag;
    logic                    neg0;
    logic                    neg1;
    logic                    neg2;
    logic [DIV_W-1:0]        mag0;
    logic [LL_W-1:0]         pp_ll;
    logic [LH_W-1:0]         pp_lh;
    logic [HL_W-1:0]         pp_hl;
    logic [HH_W-1:0]         pp_hh;
    logic [PROD_W-1:0]       prod;
    logic [DIV_W-1:0]        quo;

    assign din = (ln == 0) ? in_a : in_b;
    assign mag = din[DIV_W-1] ? -din : din;

    always_ff @(posedge clk) begin
      if (en) begin
        neg0  <= din[DIV_W-1];
        mag0  <= mag;
        neg1  <= neg0;
        pp_ll <= LL_W'(mag0[LO_W-1:0]) * LL_W'(REC_LO);
        pp_lh <= LH_W'(mag0[LO_W-1:0]) * LH_W'(REC_HI);
        pp_hl <= HL_W'(mag0[DIV_W-1:LO_W]) * HL_W'(REC_LO);
        pp_hh <= HH_W'(mag0[DIV_W-1:LO_W]) * HH_W'(REC_HI);
        neg2  <= neg1;
        quo   <= DIV_W'(prod[PROD_W-1:SHIFT]);
      end
    end

    assign prod = PROD_W'(pp_ll) + (PROD_W'(pp_lh) << RLO_W)
                + (PROD_W'(pp_hl) << LO_W) + (PROD_W'(pp_hh) << (LO_W + RLO_W));
    assign lane_quo[ln] = neg2 ? -quo : quo;
  end

  assign out_valid = valid2;
  assign out_a     = lane_quo[0][OUT_W-1:0];
  assign out_b     = lane_quo[1][OUT_W-1:0];
  assign out_tag   = tag2;

endmodule
